// ===== design/vrp_pkg.sv =====
// Shared types, constants and register indexes of the vertex rotate and project block.
package vrp_pkg;

	// Screen and object limits
	localparam int SCREEN_WIDTH  = 720;
	localparam int SCREEN_HEIGHT = 720;
	localparam int MAX_VERTICES  = 4096;
	localparam int FOCAL         = 200;

	// Field widths
	localparam int COORD_W = 32;
	localparam int TRIG_W  = 16;
	localparam int SCR_W   = 16;
	localparam int CNT_W   = 13;
	localparam int IDX_W   = 3;

	// Tally stops at the object limit or at the field maximum, whichever is smaller
	localparam int CNT_MAX   = (1 << CNT_W) - 1;
	localparam int TALLY_CAP = (MAX_VERTICES < CNT_MAX) ? MAX_VERTICES : CNT_MAX;

	// Fixed-point datapath widths
	localparam int FRAC_BITS = 14;           // Q1.14 trig scaling
	localparam int ROT1_W    = 35;           // x1, z1 after the Y rotation
	localparam int TX_W      = 36;           // x1 + offset_x
	localparam int TY_W      = 38;           // y1 + offset_y, z2 + offset_z
	localparam int OPA_W     = TY_W;         // multiplier coordinate operand
	localparam int ACC_W     = 56;           // product sum accumulator
	localparam int NUM_W     = 52;           // projection numerator
	localparam int DEN_W     = TY_W - 1;     // positive depth magnitude
	localparam int QB        = SCR_W + 1;    // quotient bits produced serially
	localparam int QCNT_W    = $clog2(QB);

	// Multiplier constants for projection and screen bounds
	localparam logic signed [TRIG_W-1:0] FOCAL_C  = TRIG_W'(FOCAL);
	localparam logic signed [TRIG_W-1:0] HALF_W_C = TRIG_W'(SCREEN_WIDTH / 2);
	localparam logic signed [TRIG_W-1:0] HALF_H_C = TRIG_W'(SCREEN_HEIGHT / 2);
	localparam logic signed [SCR_W-1:0]  SCR_X_MAX = SCR_W'(SCREEN_WIDTH);
	localparam logic signed [SCR_W-1:0]  SCR_Y_MAX = SCR_W'(SCREEN_HEIGHT);

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_SIN_X    = 3'd0;
	localparam logic [IDX_W-1:0] REG_COS_X    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SIN_Y    = 3'd2;
	localparam logic [IDX_W-1:0] REG_COS_Y    = 3'd3;
	localparam logic [IDX_W-1:0] REG_OFFSET_X = 3'd4;
	localparam logic [IDX_W-1:0] REG_OFFSET_Y = 3'd5;
	localparam logic [IDX_W-1:0] REG_OFFSET_Z = 3'd6;

	// Configuration reset values
	localparam logic signed [TRIG_W-1:0]  TRIG_ONE     = 16'sd16384;
	localparam logic signed [COORD_W-1:0] OFFSET_Z_RST = 32'sd327680;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic signed [COORD_W-1:0] vertex_z;
		logic                      first_of_object;
	} vrp_in_t;

	typedef struct packed {
		logic signed [SCR_W-1:0] screen_x;
		logic signed [SCR_W-1:0] screen_y;
		logic                    in_front;
		logic                    in_bounds;
		logic [CNT_W-1:0]        visible_count;
	} vrp_out_t;

	// Multiply-accumulate control
	typedef struct packed {
		logic mul_en;   // capture a new product
		logic acc_en;   // update the accumulator
		logic load;     // start a new sum from the product
		logic sub;      // subtract the product instead of adding
	} vrp_mac_ctl_t;

endpackage

// ===== design/vertex_rotate_project.sv =====
// Top level: configuration registers, step sequencer, projection and visible tally.
//
//  channel   direction  handshake               beat contents
//  in        input      in_valid / in_ready     vrp_in_t: vertex x, y, z, first_of_object
//  out       output     out_valid / out_ready   vrp_out_t: screen x, y, flags, visible_count
//  cfg       input      cfg_we                  cfg_index, cfg_wdata (no read-back)
//
// Each vertex is taken in the idle state, then runs through the steps of the shared
// multiply-accumulate unit (rotation, offsets and both projection numerators), two passes
// of the serial divider (x, then y) and a finish state; a vertex behind the camera skips
// the divider. Reset clears control state, the tally and the configuration registers
// to their defaults. in_ready is high only while the sequencer is idle; a finished result
// waits in the output register while the next vertex is taken, and the sequencer stalls
// at the end only if that register is still full.
module vertex_rotate_project import vrp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vrp_in_t             in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output vrp_out_t            out_data,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [COORD_W-1:0]  cfg_wdata
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_DIVX = 5'b00100,
		S_DIVY = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	// Multiply steps: the operand pair presented in that cycle
	typedef enum logic [3:0] {
		ST_XCY  = 4'd0,   // vx * cos_y
		ST_ZSY  = 4'd1,   // vz * sin_y
		ST_XSY  = 4'd2,   // vx * sin_y
		ST_ZCY  = 4'd3,   // vz * cos_y
		ST_YCX  = 4'd4,   // vy * cos_x
		ST_Z1SX = 4'd5,   // z1 * sin_x
		ST_YSX  = 4'd6,   // vy * sin_x
		ST_Z1CX = 4'd7,   // z1 * cos_x
		ST_TXF  = 4'd8,   // tx * focal
		ST_TZHW = 4'd9,   // tz * half width
		ST_TYF  = 4'd10,  // ty * focal
		ST_TZHH = 4'd11,  // tz * half height
		ST_LAST = 4'd12   // last accumulate only
	} step_t;

	state_t state_q;
	step_t  step_q;

	logic signed [TRIG_W-1:0]  sin_x_q, cos_x_q, sin_y_q, cos_y_q;
	logic signed [COORD_W-1:0] offset_x_q, offset_y_q, offset_z_q;

	logic signed [COORD_W-1:0] vx_q, vy_q, vz_q;
	logic                      first_q;
	logic signed [ROT1_W-1:0]  z1_q;
	logic signed [TX_W-1:0]    tx_q;
	logic signed [TY_W-1:0]    ty_q, tz_q;
	logic signed [NUM_W-1:0]   numx_q, numy_q;
	logic signed [SCR_W-1:0]   sx_q, sy_q;
	logic [CNT_W-1:0]          tally_q;
	logic                      out_valid_q;
	vrp_out_t                  out_q;

	logic signed [OPA_W-1:0]   op_a;
	logic signed [TRIG_W-1:0]  op_b;
	vrp_mac_ctl_t              mac_ctl;
	logic signed [ACC_W-1:0]   sum;
	logic signed [ACC_W-1:0]   sh;

	logic                      div_start;
	logic                      div_done;
	logic signed [NUM_W-1:0]   div_num;
	logic signed [SCR_W-1:0]   div_quo;

	logic                      front;
	logic                      inb;
	logic [CNT_W-1:0]          tally_base;
	logic [CNT_W-1:0]          tally_next;
	logic                      out_free;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_x_q    <= '0;
			cos_x_q    <= TRIG_ONE;
			sin_y_q    <= '0;
			cos_y_q    <= TRIG_ONE;
			offset_x_q <= '0;
			offset_y_q <= '0;
			offset_z_q <= OFFSET_Z_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIN_X:    sin_x_q    <= cfg_wdata[TRIG_W-1:0];
				REG_COS_X:    cos_x_q    <= cfg_wdata[TRIG_W-1:0];
				REG_SIN_Y:    sin_y_q    <= cfg_wdata[TRIG_W-1:0];
				REG_COS_Y:    cos_y_q    <= cfg_wdata[TRIG_W-1:0];
				REG_OFFSET_X: offset_x_q <= cfg_wdata;
				REG_OFFSET_Y: offset_y_q <= cfg_wdata;
				REG_OFFSET_Z: offset_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Select the operand pair for this step
	always_comb begin
		op_a = OPA_W'(vx_q);
		op_b = cos_y_q;
		case (step_q)
			ST_XCY: begin
				op_a = OPA_W'(vx_q);
				op_b = cos_y_q;
			end
			ST_ZSY: begin
				op_a = OPA_W'(vz_q);
				op_b = sin_y_q;
			end
			ST_XSY: begin
				op_a = OPA_W'(vx_q);
				op_b = sin_y_q;
			end
			ST_ZCY: begin
				op_a = OPA_W'(vz_q);
				op_b = cos_y_q;
			end
			ST_YCX: begin
				op_a = OPA_W'(vy_q);
				op_b = cos_x_q;
			end
			ST_Z1SX: begin
				op_a = OPA_W'(z1_q);
				op_b = sin_x_q;
			end
			ST_YSX: begin
				op_a = OPA_W'(vy_q);
				op_b = sin_x_q;
			end
			ST_Z1CX: begin
				op_a = OPA_W'(z1_q);
				op_b = cos_x_q;
			end
			ST_TXF: begin
				op_a = OPA_W'(tx_q);
				op_b = FOCAL_C;
			end
			ST_TZHW: begin
				op_a = tz_q;
				op_b = HALF_W_C;
			end
			ST_TYF: begin
				op_a = ty_q;
				op_b = FOCAL_C;
			end
			ST_TZHH: begin
				op_a = tz_q;
				op_b = HALF_H_C;
			end
			default: ;
		endcase
	end

	// The product of the previous step lands here: odd steps start a sum,
	// even steps finish it
	always_comb begin
		mac_ctl.mul_en = (state_q == S_MUL) && (step_q != ST_LAST);
		mac_ctl.acc_en = (state_q == S_MUL) && (step_q != ST_XCY);
		mac_ctl.load   = step_q[0];
		mac_ctl.sub    = (step_q == ST_XSY) || (step_q == ST_YSX);
	end

	vrp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op_a   (op_a),
		.op_b   (op_b),
		.ctl    (mac_ctl),
		.sum    (sum)
	);

	// Floor shift of the Q1.14 product sum
	assign sh = sum >>> FRAC_BITS;

	// Capture the accepted vertex, finished sums and quotients
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			vx_q    <= in_data.vertex_x;
			vy_q    <= in_data.vertex_y;
			vz_q    <= in_data.vertex_z;
			first_q <= in_data.first_of_object;
		end
		if (state_q == S_MUL) begin
			case (step_q)
				ST_XSY:  tx_q   <= TX_W'($signed(sh[ROT1_W-1:0])) + TX_W'(offset_x_q);
				ST_YCX:  z1_q   <= sh[ROT1_W-1:0];
				ST_YSX:  ty_q   <= TY_W'($signed(sh[TY_W-2:0])) + TY_W'(offset_y_q);
				ST_TXF:  tz_q   <= TY_W'($signed(sh[TY_W-2:0])) + TY_W'(offset_z_q);
				ST_TYF:  numx_q <= sum[NUM_W-1:0];
				ST_LAST: numy_q <= sum[NUM_W-1:0];
				default: ;
			endcase
		end
		// Behind the camera: screen coordinates read as zero
		if (state_q == S_MUL && step_q == ST_LAST && !front) begin
			sx_q <= '0;
			sy_q <= '0;
		end
		if (state_q == S_DIVX && div_done) begin
			sx_q <= div_quo;
		end
		if (state_q == S_DIVY && div_done) begin
			sy_q <= div_quo;
		end
	end

	assign front = (tz_q > 0);

	// Divide x first, then y, on the shared divider
	assign div_start = (state_q == S_MUL && step_q == ST_LAST && front)
		|| (state_q == S_DIVX && div_done);
	assign div_num   = (state_q == S_DIVX) ? numy_q : numx_q;

	vrp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (tz_q[DEN_W-1:0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Bounds test and visible tally
	assign inb = front && !sx_q[SCR_W-1] && (sx_q <= SCR_X_MAX)
		&& !sy_q[SCR_W-1] && (sy_q <= SCR_Y_MAX);
	assign tally_base = first_q ? '0 : tally_q;
	assign tally_next = (inb && (tally_base < CNT_W'(TALLY_CAP))) ?
		tally_base + 1'b1 : tally_base;
	assign out_free   = !out_valid_q || out_ready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_XCY;
			tally_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
						step_q  <= ST_XCY;
					end
				end
				S_MUL: begin
					if (step_q == ST_LAST) begin
						state_q <= front ? S_DIVX : S_FIN;
					end else begin
						step_q <= step_t'(step_q + 1'b1);
					end
				end
				S_DIVX: begin
					if (div_done) begin
						state_q <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						tally_q <= tally_next;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: load the result beat, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_q.screen_x      <= sx_q;
			out_q.screen_y      <= sy_q;
			out_q.in_front      <= front;
			out_q.in_bounds     <= inb;
			out_q.visible_count <= tally_next;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_bounds_needs_front: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.in_front || !out_data.in_bounds))
		else $error("in_bounds set on a vertex behind the camera");

	a_behind_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.in_front) |-> (out_data.screen_x == 0 && out_data.screen_y == 0))
		else $error("nonzero screen position on a vertex behind the camera");

	a_tally_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q <= CNT_W'(TALLY_CAP))
		else $error("visible tally beyond its cap");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIVX || state_q == S_DIVY))
		else $error("divider finished outside a divide phase");
`endif

endmodule

// ===== design/vrp_mac.sv =====
// Shared signed multiplier with registered product and accumulator.
module vrp_mac import vrp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [OPA_W-1:0]  op_a,
	input  logic signed [TRIG_W-1:0] op_b,
	input  vrp_mac_ctl_t             ctl,
	output logic signed [ACC_W-1:0]  sum
);

	logic signed [OPA_W+TRIG_W-1:0] prod_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [ACC_W-1:0]        prod_ext;

	// Register the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
		end else if (ctl.mul_en) begin
			prod_q <= op_a * op_b;
		end
	end

	// Load, add or subtract the last product
	assign prod_ext = ACC_W'(prod_q);

	always_comb begin
		if (ctl.load) begin
			sum = prod_ext;
		end else if (ctl.sub) begin
			sum = acc_q - prod_ext;
		end else begin
			sum = acc_q + prod_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= sum;
		end
	end

endmodule

// ===== design/vrp_div.sv =====
// Radix-2 restoring divider giving a saturated 16-bit quotient, truncated toward zero.
module vrp_div import vrp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]         den,
	output logic                     done,
	output logic signed [SCR_W-1:0]  quo
);

	logic [NUM_W-1:0]    mag;
	logic [NUM_W-QB-1:0] hi;
	logic [DEN_W:0]      rem_q;
	logic [DEN_W-1:0]    den_q;
	logic [QB-1:0]       low_q;
	logic [QB-1:0]       qbits_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                neg_q;
	logic                ovf_q;
	logic                run_q;
	logic                done_q;
	logic [DEN_W:0]      trial;
	logic                fits;
	logic [QB-1:0]       neg_mag;

	// Split the numerator magnitude: upper part seeds the remainder
	assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign hi  = mag[NUM_W-1:QB];

	// One quotient bit per cycle
	assign trial = {rem_q[DEN_W-1:0], low_q[QB-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == QCNT_W'(QB - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q   <= den;
			neg_q   <= num[NUM_W-1];
			ovf_q   <= (DEN_W+1)'(hi) >= {1'b0, den};
			rem_q   <= (DEN_W+1)'(hi);
			low_q   <= mag[QB-1:0];
			qbits_q <= '0;
		end else if (run_q) begin
			rem_q   <= fits ? (trial - {1'b0, den_q}) : trial;
			low_q   <= {low_q[QB-2:0], 1'b0};
			qbits_q <= {qbits_q[QB-2:0], fits};
		end
	end

	// Apply sign and saturate
	assign neg_mag = QB'(0) - qbits_q;

	always_comb begin
		if (ovf_q) begin
			quo = neg_q ? {1'b1, {(SCR_W-1){1'b0}}} : {1'b0, {(SCR_W-1){1'b1}}};
		end else if (neg_q) begin
			if (qbits_q > {2'b01, {(QB-2){1'b0}}}) begin
				quo = {1'b1, {(SCR_W-1){1'b0}}};
			end else begin
				quo = neg_mag[SCR_W-1:0];
			end
		end else begin
			if (qbits_q[QB-1:SCR_W-1] != '0) begin
				quo = {1'b0, {(SCR_W-1){1'b1}}};
			end else begin
				quo = qbits_q[SCR_W-1:0];
			end
		end
	end

	assign done = done_q;

endmodule
